>>> rtl/psu_pkg.sv
// psu_pkg: shared types, constants and the Paeth predictor for the PNG scanline unfilter.
// Depends on nothing; used by psu_recon, png_scanline_unfilter_top and psu_checker.
package psu_pkg;

  localparam int BYTE_W     = 8;
  localparam int BPP_W      = 4;
  localparam int LEN_W      = 14;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 14;

  localparam logic [CFG_IDX_W-1:0] CFG_BPP = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LEN = 2'd1;

  localparam logic [BPP_W-1:0] BPP_RESET = 4'd4;
  localparam logic [LEN_W-1:0] LEN_RESET = 14'd1024;

  localparam logic [BYTE_W-1:0] FT_NONE  = 8'd0;
  localparam logic [BYTE_W-1:0] FT_SUB   = 8'd1;
  localparam logic [BYTE_W-1:0] FT_UP    = 8'd2;
  localparam logic [BYTE_W-1:0] FT_AVG   = 8'd3;
  localparam logic [BYTE_W-1:0] FT_PAETH = 8'd4;

  typedef logic [BYTE_W-1:0] byte_t;

  function automatic byte_t paeth(input byte_t a, input byte_t b, input byte_t c);
    logic signed [9:0] p;
    logic signed [9:0] da;
    logic signed [9:0] db;
    logic signed [9:0] dc;
    logic        [9:0] pa;
    logic        [9:0] pb;
    logic        [9:0] pc;
    byte_t             res;
    p  = $signed({2'b00, a}) + $signed({2'b00, b}) - $signed({2'b00, c});
    da = p - $signed({2'b00, a});
    db = p - $signed({2'b00, b});
    dc = p - $signed({2'b00, c});
    pa = (da < 0) ? 10'(-da) : 10'(da);
    pb = (db < 0) ? 10'(-db) : 10'(db);
    pc = (dc < 0) ? 10'(-dc) : 10'(dc);
    if (pa <= pb && pa <= pc) begin
      res = a;
    end else if (pb <= pc) begin
      res = b;
    end else begin
      res = c;
    end
    return res;
  endfunction

endpackage

>>> rtl/psu_ram.sv
// psu_ram: generic single-write, single-read RAM with registered read data.
// Depends on nothing; holds the line above for the scanline unfilter.
module psu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8192
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/psu_recon.sv
// psu_recon: reconstructs one data byte from its filter type and neighbors a, b, c.
// Depends on psu_pkg.
module psu_recon (
  input  psu_pkg::byte_t ftype,
  input  psu_pkg::byte_t x,
  input  psu_pkg::byte_t a,
  input  psu_pkg::byte_t b,
  input  psu_pkg::byte_t c,
  output psu_pkg::byte_t r
);

  logic [psu_pkg::BYTE_W:0] avg_sum;

  assign avg_sum = {1'b0, a} + {1'b0, b};

  always_comb begin
    unique case (ftype)
      psu_pkg::FT_SUB:   r = x + a;
      psu_pkg::FT_UP:    r = x + b;
      psu_pkg::FT_AVG:   r = x + avg_sum[psu_pkg::BYTE_W:1];
      psu_pkg::FT_PAETH: r = x + psu_pkg::paeth(a, b, c);
      default:           r = x;
    endcase
  end

endmodule

>>> rtl/png_scanline_unfilter_top.sv
// png_scanline_unfilter_top: PNG scanline reconstruction, one byte per transaction.
// Depends on psu_pkg, psu_ram (line store) and psu_recon (filter arithmetic).
//
//   channel  direction  handshake           payload
//   in_      input      in_valid/in_stall   in_data_byte, in_new_image
//   out_     output     out_valid/out_stall out_byte, out_is_type_byte, out_bad_type
//   cfg_     input      cfg_valid/cfg_ready cfg_index, cfg_data
//
// One byte per cycle while not stalled; bytes pass the s1 and result registers.
// The line store is read as a byte is taken and written when its result is formed.
// Synchronous active-low reset; the line store is not cleared.
// in_stall rises only while the result register is full and out_stall is high.
module png_scanline_unfilter_top #(
  parameter int MAX_LINE_BYTES  = 8192,
  parameter int MAX_PIXEL_BYTES = 8
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [psu_pkg::BYTE_W-1:0]       in_data_byte,
  input  logic                             in_new_image,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [psu_pkg::BYTE_W-1:0]       out_byte,
  output logic                             out_is_type_byte,
  output logic                             out_bad_type,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [psu_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [psu_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int AW = $clog2(MAX_LINE_BYTES);
  localparam int CW = (AW + 1 > psu_pkg::LEN_W) ? AW + 1 : psu_pkg::LEN_W;
  localparam int PW = (MAX_PIXEL_BYTES > 1) ? $clog2(MAX_PIXEL_BYTES) : 1;

  logic [psu_pkg::BPP_W-1:0] bpp_r;
  logic [psu_pkg::LEN_W-1:0] len_r;

  logic                   expect_type_r;
  logic                   first_row_r;
  logic [AW-1:0]          col_r;
  psu_pkg::byte_t         line_type_r;

  logic                   s1_valid_r;
  logic                   s1_type_r;
  logic                   s1_top_r;
  psu_pkg::byte_t         s1_byte_r;
  psu_pkg::byte_t         s1_ftype_r;
  logic [AW-1:0]          s1_col_r;

  logic                   out_valid_r;
  psu_pkg::byte_t         out_byte_r;
  logic                   out_type_r;
  logic                   out_bad_r;

  psu_pkg::byte_t         left_r    [MAX_PIXEL_BYTES];
  psu_pkg::byte_t         uleft_r   [MAX_PIXEL_BYTES];

  logic                   out_free;
  logic                   s1_move;
  logic                   in_acc;
  logic                   take_type;
  logic [CW-1:0]          len_eff;
  logic                   line_end;
  logic [PW-1:0]          nb_idx;
  psu_pkg::byte_t         ram_q;
  psu_pkg::byte_t         nb_a;
  psu_pkg::byte_t         nb_b;
  psu_pkg::byte_t         nb_c;
  psu_pkg::byte_t         recon;

  assign out_free  = !out_valid_r || !out_stall;
  assign s1_move   = s1_valid_r && out_free;
  assign in_stall  = s1_valid_r && !out_free;
  assign in_acc    = in_valid && !in_stall;
  assign take_type = in_new_image || expect_type_r;
  assign cfg_ready = 1'b1;

  always_comb begin
    if (len_r == '0) begin
      len_eff = CW'(1);
    end else if (CW'(len_r) > CW'(MAX_LINE_BYTES)) begin
      len_eff = CW'(MAX_LINE_BYTES);
    end else begin
      len_eff = CW'(len_r);
    end
  end

  assign line_end = (CW'(col_r) + CW'(1)) >= len_eff;

  always_comb begin
    if (bpp_r == '0) begin
      nb_idx = '0;
    end else if (bpp_r > psu_pkg::BPP_W'(MAX_PIXEL_BYTES)) begin
      nb_idx = PW'(MAX_PIXEL_BYTES - 1);
    end else begin
      nb_idx = PW'(bpp_r - psu_pkg::BPP_W'(1));
    end
  end

  assign nb_a = left_r[nb_idx];
  assign nb_c = uleft_r[nb_idx];
  assign nb_b = s1_top_r ? '0 : ram_q;

  psu_ram #(
    .WIDTH (psu_pkg::BYTE_W),
    .DEPTH (MAX_LINE_BYTES)
  ) u_line (
    .clk   (clk),
    .we    (s1_move && !s1_type_r),
    .waddr (s1_col_r),
    .wdata (recon),
    .re    (in_acc),
    .raddr (col_r),
    .rdata (ram_q)
  );

  psu_recon u_recon (
    .ftype (s1_ftype_r),
    .x     (s1_byte_r),
    .a     (nb_a),
    .b     (nb_b),
    .c     (nb_c),
    .r     (recon)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bpp_r <= psu_pkg::BPP_RESET;
      len_r <= psu_pkg::LEN_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        psu_pkg::CFG_BPP: bpp_r <= cfg_data[psu_pkg::BPP_W-1:0];
        psu_pkg::CFG_LEN: len_r <= cfg_data[psu_pkg::LEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      expect_type_r <= 1'b1;
      first_row_r   <= 1'b1;
      col_r         <= '0;
      line_type_r   <= '0;
      s1_valid_r    <= 1'b0;
    end else begin
      if (s1_move) begin
        s1_valid_r <= 1'b0;
      end
      if (in_acc) begin
        s1_valid_r <= 1'b1;
        s1_byte_r  <= in_data_byte;
        s1_col_r   <= col_r;
        s1_type_r  <= take_type;
        if (take_type) begin
          line_type_r   <= in_data_byte;
          expect_type_r <= 1'b0;
          col_r         <= '0;
          s1_ftype_r    <= in_data_byte;
          s1_top_r      <= in_new_image || first_row_r;
          if (in_new_image) begin
            first_row_r <= 1'b1;
          end
        end else begin
          s1_ftype_r <= line_type_r;
          s1_top_r   <= first_row_r;
          if (line_end) begin
            expect_type_r <= 1'b1;
            first_row_r   <= 1'b0;
            col_r         <= '0;
          end else begin
            col_r <= col_r + AW'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      for (int i = 0; i < MAX_PIXEL_BYTES; i++) begin
        left_r[i]  <= '0;
        uleft_r[i] <= '0;
      end
    end else begin
      if (out_free) begin
        out_valid_r <= s1_valid_r;
      end
      if (s1_move) begin
        out_type_r <= s1_type_r;
        out_bad_r  <= s1_ftype_r > psu_pkg::FT_PAETH;
        if (s1_type_r) begin
          out_byte_r <= s1_byte_r;
          for (int i = 0; i < MAX_PIXEL_BYTES; i++) begin
            left_r[i]  <= '0;
            uleft_r[i] <= '0;
          end
        end else begin
          out_byte_r <= recon;
          left_r[0]  <= recon;
          uleft_r[0] <= nb_b;
          for (int i = 1; i < MAX_PIXEL_BYTES; i++) begin
            left_r[i]  <= left_r[i-1];
            uleft_r[i] <= uleft_r[i-1];
          end
        end
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_byte         = out_byte_r;
  assign out_is_type_byte = out_type_r;
  assign out_bad_type     = out_bad_r;

endmodule

>>> rtl/psu_checker.sv
// psu_checker: port-level assertions for png_scanline_unfilter_top, bound to the top level.
// Depends on psu_pkg for field widths.
module psu_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_stall,
  input logic                       out_valid,
  input logic                       out_stall,
  input logic [psu_pkg::BYTE_W-1:0] out_byte,
  input logic                       out_is_type_byte,
  input logic                       out_bad_type
);

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled while the result side is free");

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> ##1 out_valid)
    else $error("accepted transaction did not reach the result register");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_byte)
      && $stable(out_is_type_byte) && $stable(out_bad_type)))
    else $error("stalled result changed");

endmodule

bind png_scanline_unfilter_top psu_checker u_psu_checker (.*);
